// File: src/lowest_free_room_allocator_macros.svh
// Assertion macros for the lowest free room allocator.
`ifndef LOWEST_FREE_ROOM_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ROOM_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define LFRA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LFRA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFRA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define LFRA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/lfra_pkg.sv
// Shared types and constants of the lowest free room allocator.
package lfra_pkg;

    localparam int ROOM_W   = 10;
    localparam int STATUS_W = 2;
    localparam int NEEDED_W = 11;
    localparam int GUEST_W  = 10;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_LEAVE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_ROOM  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_HELD = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FREE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic take;
        logic look;
        logic free;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_free;
    } dp_stat_t;

endpackage

// File: src/lfra_if.sv
// Handshake interfaces for the event, result and configuration channels.
interface lfra_evt_if;
    import lfra_pkg::*;
    logic               valid;
    logic               ready;
    logic               action;
    logic [GUEST_W-1:0] guest_id;
    modport source (output valid, action, guest_id, input ready);
    modport sink (input valid, action, guest_id, output ready);
endinterface

interface lfra_res_if;
    import lfra_pkg::*;
    logic                valid;
    logic                ready;
    logic [ROOM_W-1:0]   room;
    logic [STATUS_W-1:0] status;
    logic [NEEDED_W-1:0] rooms_needed;
    modport source (output valid, room, status, rooms_needed, input ready);
    modport sink (input valid, room, status, rooms_needed, output ready);
endinterface

interface lfra_cfg_if;
    import lfra_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] rooms_in_use;
    modport source (output valid, rooms_in_use, input ready);
    modport sink (input valid, rooms_in_use, output ready);
endinterface

// File: src/lfra_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module lfra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_ready,
    output logic              res_valid,
    input  logic              res_ready,
    input  lfra_pkg::dp_stat_t stat,
    output lfra_pkg::dp_cmd_t  cmd
);
    import lfra_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.need_free)
                begin
                    state_next = ST_FREE;
                end
                else if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        evt_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                evt_ready = 1'b1;
                cmd.take  = evt_valid;
            end
            ST_LOOK:
            begin
                cmd.look     = stat.need_free || slot_free;
                cmd.load_out = !stat.need_free && slot_free;
            end
            ST_FREE:
            begin
                cmd.free     = slot_free;
                cmd.load_out = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;

endmodule

// File: src/lfra_dp.sv
// Datapath with the free-room maps, the guest table and the result register.
module lfra_dp #(
    parameter int ROOMS      = 1024,
    parameter int BLOCK_SIZE = 32,
    parameter int GUESTS     = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lfra_pkg::dp_cmd_t               cmd,
    output lfra_pkg::dp_stat_t              stat,
    input  logic                            evt_action,
    input  logic [lfra_pkg::GUEST_W-1:0]    evt_guest_id,
    input  logic                            cfg_valid,
    input  logic [lfra_pkg::CFG_W-1:0]      cfg_rooms_in_use,
    output logic [lfra_pkg::ROOM_W-1:0]     room,
    output logic [lfra_pkg::STATUS_W-1:0]   status,
    output logic [lfra_pkg::NEEDED_W-1:0]   rooms_needed
);
    import lfra_pkg::*;

    localparam int NBLK = (ROOMS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BIW  = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int OFW  = $clog2(BLOCK_SIZE);
    localparam int CNTW = $clog2(BLOCK_SIZE + 1);
    localparam int RIW  = $clog2(ROOMS);
    localparam int LW   = $clog2(ROOMS + 1);
    localparam int GIW  = $clog2(GUESTS);
    localparam int CMPW = (LW > CFG_W) ? LW : CFG_W;
    localparam int GCW  = (GIW + 1 > GUEST_W) ? GIW + 1 : GUEST_W;

    typedef struct packed {
        logic           holds;
        logic [RIW-1:0] room;
        logic [BIW-1:0] blk;
        logic [OFW-1:0] off;
    } gent_t;

    logic [CFG_W-1:0]      rooms_in_use_reg;
    logic [NBLK-1:0]       bhf_reg;
    logic [NBLK-1:0]       bhf_next;
    logic [NBLK-1:0]       row_valid_reg;
    logic [BLOCK_SIZE-1:0] word_mem [NBLK];
    gent_t                 guest_mem [GUESTS];

    logic [GIW-1:0]        clr_idx_reg;
    logic [LW-1:0]         peak_reg;
    logic [LW-1:0]         peak_next;

    logic                  action_reg;
    logic                  grange_reg;
    logic [GIW-1:0]        gidx_reg;
    logic [BIW-1:0]        blk_reg;
    logic                  any_reg;
    logic [RIW-1:0]        base_reg;
    logic [CNTW-1:0]       avail_reg;
    logic [CNTW-1:0]       exist_reg;
    gent_t                 grd_reg;
    logic [BLOCK_SIZE-1:0] wrd_reg;
    logic                  wvld_reg;

    logic [ROOM_W-1:0]     room_out_reg;
    logic [STATUS_W-1:0]   status_out_reg;
    logic [NEEDED_W-1:0]   needed_out_reg;

    logic [BIW-1:0]        blk_enc;
    logic [RIW-1:0]        base_enc;
    logic [CMPW-1:0]       limit;
    logic [CMPW-1:0]       base_ext;
    logic [CMPW-1:0]       avail_diff;
    logic [CMPW-1:0]       exist_diff;
    logic [CNTW-1:0]       avail_enc;
    logic [CNTW-1:0]       exist_enc;
    logic                  grange;

    logic [BLOCK_SIZE-1:0] word_cur;
    logic [BLOCK_SIZE-1:0] avail_mask;
    logic [BLOCK_SIZE-1:0] exist_mask;
    logic [BLOCK_SIZE-1:0] cand;
    logic [OFW-1:0]        off_enc;
    logic                  found;
    logic [RIW-1:0]        alloc_room;
    logic                  alloc_now;
    logic [LW-1:0]         alloc_count;

    logic                  wm_re;
    logic [BIW-1:0]        wm_raddr;
    logic                  wm_we;
    logic [BIW-1:0]        wm_waddr;
    logic [BLOCK_SIZE-1:0] wm_wdata;
    logic                  gm_we;
    logic [GIW-1:0]        gm_waddr;
    gent_t                 gm_wdata;

    logic [ROOM_W-1:0]     room_sel;
    logic [STATUS_W-1:0]   status_sel;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rooms_in_use_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            rooms_in_use_reg <= cfg_rooms_in_use;
        end
    end

    // Lowest block with a free room, and how many of its rooms may be given out.
    always_comb
    begin
        blk_enc = '0;
        for (int i = NBLK - 1; i >= 0; i--)
        begin
            if (bhf_reg[i])
            begin
                blk_enc = BIW'(i);
            end
        end
        base_enc   = RIW'(blk_enc * BLOCK_SIZE);
        base_ext   = CMPW'(base_enc);
        limit      = (CMPW'(rooms_in_use_reg) > CMPW'(ROOMS)) ? CMPW'(ROOMS)
                                                              : CMPW'(rooms_in_use_reg);
        avail_diff = (limit > base_ext) ? (limit - base_ext) : '0;
        avail_enc  = (avail_diff > CMPW'(BLOCK_SIZE)) ? CNTW'(BLOCK_SIZE)
                                                      : CNTW'(avail_diff);
        exist_diff = CMPW'(ROOMS) - base_ext;
        exist_enc  = (exist_diff > CMPW'(BLOCK_SIZE)) ? CNTW'(BLOCK_SIZE)
                                                      : CNTW'(exist_diff);
        grange     = GCW'(evt_guest_id) < GCW'(GUESTS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            action_reg <= evt_action;
            grange_reg <= grange;
            gidx_reg   <= GIW'(evt_guest_id);
            blk_reg    <= blk_enc;
            any_reg    <= |bhf_reg;
            base_reg   <= base_enc;
            avail_reg  <= avail_enc;
            exist_reg  <= exist_enc;
        end
    end

    // Search inside the chosen block.
    always_comb
    begin
        word_cur = wvld_reg ? wrd_reg : '1;
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            avail_mask[i] = CNTW'(i) < avail_reg;
            exist_mask[i] = CNTW'(i) < exist_reg;
        end
        cand    = word_cur & avail_mask;
        off_enc = '0;
        for (int i = BLOCK_SIZE - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                off_enc = OFW'(i);
            end
        end
        found       = any_reg && (|cand);
        alloc_room  = base_reg + RIW'(off_enc);
        alloc_count = LW'(alloc_room) + LW'(1);
    end

    assign alloc_now = cmd.look && (action_reg == ACT_ARRIVE) && grange_reg
                       && !grd_reg.holds && found;

    assign stat.need_free  = (action_reg == ACT_LEAVE) && grange_reg && grd_reg.holds;
    assign stat.clear_last = clr_idx_reg == GIW'(GUESTS - 1);

    // Room word memory: one read and one write port.
    always_comb
    begin
        wm_re    = cmd.take || (cmd.look && stat.need_free);
        wm_raddr = cmd.take ? blk_enc : grd_reg.blk;
        wm_we    = alloc_now || cmd.free;
        wm_waddr = cmd.free ? grd_reg.blk : blk_reg;
        wm_wdata = cmd.free ? (word_cur | (BLOCK_SIZE'(1) << grd_reg.off))
                            : (word_cur & ~(BLOCK_SIZE'(1) << off_enc));
        bhf_next = bhf_reg;
        if (cmd.free)
        begin
            bhf_next[grd_reg.blk] = 1'b1;
        end
        else if (alloc_now)
        begin
            bhf_next[blk_reg] = |(wm_wdata & exist_mask);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            word_mem[wm_waddr] <= wm_wdata;
        end
        if (wm_re)
        begin
            wrd_reg <= word_mem[wm_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            bhf_reg       <= '1;
            wvld_reg      <= 1'b0;
        end
        else
        begin
            bhf_reg <= bhf_next;
            if (wm_we)
            begin
                row_valid_reg[wm_waddr] <= 1'b1;
            end
            if (wm_re)
            begin
                wvld_reg <= row_valid_reg[wm_raddr];
            end
        end
    end

    // Guest table: one read and one write port, cleared after reset.
    always_comb
    begin
        gm_we    = cmd.clear_step || alloc_now || cmd.free;
        gm_waddr = cmd.clear_step ? clr_idx_reg : gidx_reg;
        gm_wdata = '0;
        if (alloc_now)
        begin
            gm_wdata.holds = 1'b1;
            gm_wdata.room  = alloc_room;
            gm_wdata.blk   = blk_reg;
            gm_wdata.off   = off_enc;
        end
        else if (cmd.free)
        begin
            gm_wdata       = grd_reg;
            gm_wdata.holds = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gm_we)
        begin
            guest_mem[gm_waddr] <= gm_wdata;
        end
        if (cmd.take)
        begin
            grd_reg <= guest_mem[GIW'(evt_guest_id)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            peak_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + GIW'(1);
            end
            peak_reg <= peak_next;
        end
    end

    // Result selection.
    always_comb
    begin
        peak_next = peak_reg;
        if (alloc_now && (alloc_count > peak_reg))
        begin
            peak_next = alloc_count;
        end
        room_sel   = '0;
        status_sel = STAT_OK;
        if (cmd.free)
        begin
            room_sel = ROOM_W'(grd_reg.room);
        end
        else if (action_reg == ACT_ARRIVE)
        begin
            if (!grange_reg)
            begin
                status_sel = STAT_NO_ROOM;
            end
            else if (grd_reg.holds)
            begin
                room_sel = ROOM_W'(grd_reg.room);
            end
            else if (found)
            begin
                room_sel = ROOM_W'(alloc_room);
            end
            else
            begin
                status_sel = STAT_NO_ROOM;
            end
        end
        else
        begin
            status_sel = STAT_NOT_HELD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            room_out_reg   <= room_sel;
            status_out_reg <= status_sel;
            needed_out_reg <= NEEDED_W'(peak_next);
        end
    end

    assign room         = room_out_reg;
    assign status       = status_out_reg;
    assign rooms_needed = needed_out_reg;

endmodule

// File: src/lowest_free_room_allocator.sv
// Top level of the lowest free room allocator.
// The evt channel carries one item per event: action (arrive or leave) and
// guest_id. The res channel returns one item per event: room, status and
// rooms_needed, the highest room ever assigned plus one. The cfg channel
// writes rooms_in_use and is always ready.
// An arrive gives the guest the lowest free room below rooms_in_use, or the
// room it already holds; a leave frees its room. Failed events report room zero.
// An arrive loads the output register from the look step; a leave that frees
// a held room passes through the free step first. A new event is taken only
// after the last one has loaded its result, as the guest table and room word
// memory are read through registers and a leave writes back into that memory.
// After reset the block runs a clearing pass over the guest table with
// evt.ready low; configuration writes are taken during it.
// The result sits in an output register until res.ready takes it. Meanwhile
// one more item is accepted and waits at its decision step until the
// register is free, and evt.ready stays low behind it.
`include "lowest_free_room_allocator_macros.svh"

module lowest_free_room_allocator #(
    parameter int ROOMS      = 1024,
    parameter int BLOCK_SIZE = 32,
    parameter int GUESTS     = 1024
) (
    input logic               clk,
    input logic               rst_n,
    lfra_evt_if.sink          evt,
    lfra_res_if.source        res,
    lfra_cfg_if.sink          cfg
);
    import lfra_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    lfra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfra_dp #(
        .ROOMS      (ROOMS),
        .BLOCK_SIZE (BLOCK_SIZE),
        .GUESTS     (GUESTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .evt_action       (evt.action),
        .evt_guest_id     (evt.guest_id),
        .cfg_valid        (cfg.valid),
        .cfg_rooms_in_use (cfg.rooms_in_use),
        .room             (res.room),
        .status           (res.status),
        .rooms_needed     (res.rooms_needed)
    );

    `LFRA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, evt.valid && evt.ready, !evt.ready, "ready stayed high after an item was taken")
    `LFRA_ASSERT_IMPL(a_load_needs_slot, clk, rst_n, cmd.load_out, !res.valid || res.ready, "result loaded over a waiting result")
    `LFRA_ASSERT_IMPL(a_fail_room_zero, clk, rst_n, res.valid && (res.status != STAT_OK), res.room == '0, "failed event reports a nonzero room")

endmodule
